// ----- rtl/core/priority_ready_map_scheduler_assert.svh -----
// Assertion macros for the scheduler checker.
// Each expects clk and rst_n in the calling scope.
`ifndef PRIORITY_READY_MAP_SCHEDULER_ASSERT_SVH
`define PRIORITY_READY_MAP_SCHEDULER_ASSERT_SVH

// Consequent checked in the same cycle.
`define PRMS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PRMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/prms_pkg.sv -----
package prms_pkg;

    localparam int unsigned MAX_TASKS_DEF = 64;
    localparam int unsigned ROW_COUNT     = 8;
    localparam int unsigned ROW_WIDTH     = 8;
    localparam int unsigned MAP_W         = ROW_COUNT * ROW_WIDTH;
    localparam int unsigned TASK_W        = 6;
    localparam int unsigned COUNT_W       = 7;
    localparam int unsigned MODE_W        = 3;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned TSTATE_W      = 2;
    localparam int unsigned CFG_IDX_W     = 1;
    localparam int unsigned CFG_DATA_W    = 64;

    typedef logic [TASK_W-1:0]    task_id_t;
    typedef logic [ROW_WIDTH-1:0] row_t;
    typedef logic [MAP_W-1:0]     map_t;
    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [STATUS_W-1:0]  status_t;
    typedef logic [TSTATE_W-1:0]  tstate_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam mode_t MODE_ACTIVATE = 3'd0;
    localparam mode_t MODE_DISPATCH = 3'd1;
    localparam mode_t MODE_FINISH   = 3'd2;
    localparam mode_t MODE_QUERY    = 3'd3;
    localparam mode_t MODE_START    = 3'd4;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_BAD_ID    = 2'd1;
    localparam status_t STATUS_NO_RESUME = 2'd2;

    localparam tstate_t TSTATE_SUSPENDED = 2'd0;
    localparam tstate_t TSTATE_READY     = 2'd1;
    localparam tstate_t TSTATE_RUNNING   = 2'd2;

    localparam cfg_idx_t CFG_TASK_COUNT = 1'b0;
    localparam cfg_idx_t CFG_AUTOSTART  = 1'b1;

    localparam task_id_t IDLE_TASK = '0;
    localparam row_t     EMPTY_ROW = 8'h00;

    typedef struct packed {
        logic     load;
        map_t     load_bits;
        logic     mark_en;
        task_id_t mark_id;
        logic     unmark_en;
        task_id_t unmark_id;
    } map_ctrl_t;

    typedef struct packed {
        task_id_t best_id;
        logic     query_ready;
    } map_view_t;

    function automatic logic [2:0] lead_one(row_t v);
        logic [2:0] p;
        p = '0;
        for (int i = 0; i < ROW_WIDTH; i++)
        begin
            if (v[i])
            begin
                p = 3'(i);
            end
        end
        return p;
    endfunction

endpackage

// ----- rtl/core/priority_ready_map_scheduler.sv -----
// Channel   | Handshake             | Payload
// ----------+-----------------------+---------------------------------------------
// command   | in_valid / in_stall   | mode, task_id
// result    | out_valid / out_stall | status, switched, running_task, task_state
// config    | cfg_we                | cfg_index, cfg_data
//
// One command per cycle while the result is not stalled. A command is held in the
// command register and its result in the result register, with the combinational
// map search and the stack update between the two registers.
// Reset empties the ready map and the stack and makes task 0 current.
// A stalled result holds the command stage; one further command waits there.
module priority_ready_map_scheduler #(
    parameter int unsigned MAX_TASKS = prms_pkg::MAX_TASKS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  prms_pkg::mode_t                     mode,
    input  prms_pkg::task_id_t                  task_id,
    output logic                                out_valid,
    input  logic                                out_stall,
    output prms_pkg::status_t                   status,
    output logic                                switched,
    output prms_pkg::task_id_t                  running_task,
    output prms_pkg::tstate_t                   task_state,
    input  logic                                cfg_we,
    input  prms_pkg::cfg_idx_t                  cfg_index,
    input  logic [prms_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned DEPTH_W = $clog2(MAX_TASKS + 1);
    localparam int unsigned ADDR_W  = $clog2(MAX_TASKS);

    logic [prms_pkg::COUNT_W-1:0]   task_count_reg;
    prms_pkg::map_t                 autostart_reg;
    logic [prms_pkg::COUNT_W-1:0]   eff_count;
    prms_pkg::map_t                 start_bits;

    logic                           in_valid_reg;
    prms_pkg::mode_t                mode_reg;
    prms_pkg::task_id_t             id_reg;
    logic                           advance;
    logic                           fire;

    prms_pkg::task_id_t             current_reg;
    prms_pkg::task_id_t             current_next;
    logic [DEPTH_W-1:0]             depth_reg;
    logic [DEPTH_W-1:0]             depth_next;
    prms_pkg::task_id_t             top_reg;
    prms_pkg::task_id_t             top_next;
    logic                           fwd_reg;
    prms_pkg::task_id_t             fwd_data_reg;
    prms_pkg::task_id_t             rd_data_reg;
    prms_pkg::task_id_t             second;
    prms_pkg::task_id_t             stack_mem [MAX_TASKS];
    logic                           push;
    logic [ADDR_W-1:0]              wr_addr;
    logic [ADDR_W-1:0]              rd_addr;

    prms_pkg::map_ctrl_t            map_ctrl;
    prms_pkg::map_view_t            map_view;

    logic                           out_valid_reg;
    prms_pkg::status_t              status_reg;
    prms_pkg::status_t              status_next;
    logic                           switched_reg;
    logic                           switched_next;
    prms_pkg::task_id_t             running_reg;
    prms_pkg::tstate_t              tstate_reg;
    prms_pkg::tstate_t              tstate_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= prms_pkg::COUNT_W'(64);
            autostart_reg  <= prms_pkg::MAP_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                prms_pkg::CFG_TASK_COUNT: task_count_reg <= cfg_data[prms_pkg::COUNT_W-1:0];
                prms_pkg::CFG_AUTOSTART:  autostart_reg  <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        if (task_count_reg > prms_pkg::COUNT_W'(MAX_TASKS))
        begin
            eff_count = prms_pkg::COUNT_W'(MAX_TASKS);
        end
        else
        begin
            eff_count = task_count_reg;
        end
        for (int t = 0; t < prms_pkg::MAP_W; t++)
        begin
            start_bits[t] = autostart_reg[t] && (prms_pkg::COUNT_W'(t) < eff_count);
        end
    end

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            mode_reg <= mode;
            id_reg   <= task_id;
        end
    end

    prms_ready_map u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (map_ctrl),
        .query_id (id_reg),
        .view     (map_view)
    );

    assign second = fwd_reg ? fwd_data_reg : rd_data_reg;

    always_comb
    begin
        map_ctrl           = '0;
        map_ctrl.load_bits = start_bits;
        current_next       = current_reg;
        depth_next         = depth_reg;
        top_next           = top_reg;
        push               = 1'b0;
        status_next        = prms_pkg::STATUS_OK;
        switched_next      = 1'b0;
        tstate_next        = prms_pkg::TSTATE_SUSPENDED;
        if (fire)
        begin
            unique case (mode_reg)
                prms_pkg::MODE_ACTIVATE:
                begin
                    if ({1'b0, id_reg} < eff_count)
                    begin
                        map_ctrl.mark_en = 1'b1;
                        map_ctrl.mark_id = id_reg;
                    end
                    else
                    begin
                        status_next = prms_pkg::STATUS_BAD_ID;
                    end
                end
                prms_pkg::MODE_DISPATCH:
                begin
                    if (map_view.best_id > current_reg)
                    begin
                        if (depth_reg < DEPTH_W'(MAX_TASKS))
                        begin
                            push       = 1'b1;
                            depth_next = depth_reg + DEPTH_W'(1);
                            top_next   = current_reg;
                        end
                        map_ctrl.mark_en   = 1'b1;
                        map_ctrl.mark_id   = current_reg;
                        map_ctrl.unmark_en = 1'b1;
                        map_ctrl.unmark_id = map_view.best_id;
                        current_next       = map_view.best_id;
                        switched_next      = 1'b1;
                    end
                end
                prms_pkg::MODE_FINISH:
                begin
                    if (depth_reg == '0)
                    begin
                        status_next = prms_pkg::STATUS_NO_RESUME;
                    end
                    else
                    begin
                        depth_next         = depth_reg - DEPTH_W'(1);
                        map_ctrl.unmark_en = 1'b1;
                        map_ctrl.unmark_id = top_reg;
                        current_next       = top_reg;
                        top_next           = second;
                        switched_next      = 1'b1;
                    end
                end
                prms_pkg::MODE_QUERY:
                begin
                    if (id_reg == current_reg)
                    begin
                        tstate_next = prms_pkg::TSTATE_RUNNING;
                    end
                    else if (map_view.query_ready)
                    begin
                        tstate_next = prms_pkg::TSTATE_READY;
                    end
                end
                prms_pkg::MODE_START:
                begin
                    map_ctrl.load = 1'b1;
                    current_next  = prms_pkg::IDLE_TASK;
                    depth_next    = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_reg <= prms_pkg::IDLE_TASK;
            depth_reg   <= '0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            current_reg <= current_next;
            depth_reg   <= depth_next;
            fwd_reg     <= push;
        end
    end

    // top of stack lives in top_reg; the entry below is prefetched from memory
    assign wr_addr = ADDR_W'(depth_reg - DEPTH_W'(1));
    assign rd_addr = ADDR_W'(depth_next - DEPTH_W'(2));

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        fwd_data_reg <= top_reg;
        if (push && depth_reg != '0)
        begin
            stack_mem[wr_addr] <= top_reg;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg   <= status_next;
            switched_reg <= switched_next;
            running_reg  <= current_next;
            tstate_reg   <= tstate_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign switched     = switched_reg;
    assign running_task = running_reg;
    assign task_state   = tstate_reg;

endmodule

// ----- rtl/core/prms_ready_map.sv -----
module prms_ready_map (
    input  logic                  clk,
    input  logic                  rst_n,
    input  prms_pkg::map_ctrl_t   ctrl,
    input  prms_pkg::task_id_t    query_id,
    output prms_pkg::map_view_t   view
);

    prms_pkg::map_t                       ready_reg;
    prms_pkg::map_t                       ready_next;
    logic [prms_pkg::ROW_COUNT-1:0]       group_reg;
    logic [prms_pkg::ROW_COUNT-1:0]       group_next;
    logic [2:0]                           top_row;
    logic [2:0]                           top_col;
    prms_pkg::row_t                       sel_row;

    always_comb
    begin
        ready_next = ready_reg;
        if (ctrl.load)
        begin
            ready_next = ctrl.load_bits;
        end
        if (ctrl.mark_en)
        begin
            ready_next[ctrl.mark_id] = 1'b1;
        end
        if (ctrl.unmark_en)
        begin
            ready_next[ctrl.unmark_id] = 1'b0;
        end
        for (int y = 0; y < prms_pkg::ROW_COUNT; y++)
        begin
            group_next[y] = (ready_next[y*prms_pkg::ROW_WIDTH +: prms_pkg::ROW_WIDTH]
                             != prms_pkg::EMPTY_ROW);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= '0;
            group_reg <= '0;
        end
        else
        begin
            ready_reg <= ready_next;
            group_reg <= group_next;
        end
    end

    // search group first, then the chosen row
    always_comb
    begin
        top_row = prms_pkg::lead_one(group_reg);
        sel_row = ready_reg[{top_row, 3'b000} +: prms_pkg::ROW_WIDTH];
        top_col = prms_pkg::lead_one(sel_row);
        if (group_reg == prms_pkg::EMPTY_ROW)
        begin
            view.best_id = prms_pkg::IDLE_TASK;
        end
        else
        begin
            view.best_id = {top_row, top_col};
        end
        view.query_ready = group_reg[query_id[5:3]] && ready_reg[query_id];
    end

endmodule

// ----- rtl/core/prms_check.sv -----
`include "priority_ready_map_scheduler_assert.svh"

module prms_check (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input prms_pkg::status_t    status,
    input logic                 switched,
    input prms_pkg::task_id_t   running_task,
    input prms_pkg::tstate_t    task_state
);

    // hold a stalled result transaction
    `PRMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(status) && $stable(switched)
            && $stable(running_task) && $stable(task_state),
        "stalled result changed")

    `PRMS_ASSERT_SAME(a_switch_ok, out_valid && switched,
        status == prms_pkg::STATUS_OK,
        "switch reported with error status")

    `PRMS_ASSERT_SAME(a_query_only, out_valid && task_state != prms_pkg::TSTATE_SUSPENDED,
        !switched && status == prms_pkg::STATUS_OK,
        "query answer on a non-query result")

    `PRMS_ASSERT_SAME(a_codes, out_valid,
        status <= prms_pkg::STATUS_NO_RESUME && task_state <= prms_pkg::TSTATE_RUNNING,
        "unused result code")

endmodule

bind priority_ready_map_scheduler prms_check u_prms_check (.*);

// ----- tb/tb_top.sv -----
module tb_top;
    import prms_pkg::*;

    localparam mode_t MODE_UNUSED_LO = 3'd5;
    localparam mode_t MODE_UNUSED_HI = 3'd7;
    localparam int    PHASES         = 10;
    localparam int    PHASE_ITEMS    = 200;
    localparam int    STALL_LIMIT    = 4000;
    localparam int    HOLD_CYCLES    = 150;
    localparam int    DRAIN_CYCLES   = 10;
    localparam int    MAX_REPORTS    = 200;

    typedef struct packed {
        status_t  status;
        logic     switched;
        task_id_t running;
        tstate_t  tstate;
    } sched_result_t;

    typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t     kind;
        mode_t         mode;
        task_id_t      id;
        cfg_idx_t      reg_idx;
        logic [63:0]   reg_val;
        bit            typed;
        sched_result_t want;
    } plan_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    mode_t              mode;
    task_id_t           task_id;
    logic               out_valid;
    logic               out_stall;
    status_t            status;
    logic               switched;
    task_id_t           running_task;
    tstate_t            task_state;
    logic               cfg_we;
    cfg_idx_t           cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [7:0]    grp_mask;
    logic [7:0]    row_mask [8];
    task_id_t      cur_task;
    task_id_t      preempt_stk [64];
    int unsigned   stk_depth;
    logic [6:0]    count_reg;
    logic [63:0]   autostart_reg;

    bit            cmd_typed;
    sched_result_t cmd_want;
    sched_result_t want_q [$];
    int            fail_count;
    int            quiet_cycles;
    bit            hold_armed;

    priority_ready_map_scheduler uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .task_id      (task_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .switched     (switched),
        .running_task (running_task),
        .task_state   (task_state),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned top_bit(logic [7:0] v);
        int unsigned p;
        p = 0;
        for (int i = 0; i < 8; i++)
        begin
            if (v[i])
            begin
                p = i;
            end
        end
        return p;
    endfunction

    function automatic int unsigned live_count();
        return (count_reg > 7'd64) ? 64 : count_reg;
    endfunction

    function automatic void ready_set(task_id_t t);
        grp_mask[t[5:3]] = 1'b1;
        row_mask[t[5:3]][t[2:0]] = 1'b1;
    endfunction

    function automatic void ready_clear(task_id_t t);
        row_mask[t[5:3]][t[2:0]] = 1'b0;
        if (row_mask[t[5:3]] == EMPTY_ROW)
        begin
            grp_mask[t[5:3]] = 1'b0;
        end
    endfunction

    task automatic sched_apply(input mode_t m, input task_id_t id, output sched_result_t r);
        int unsigned best;
        int unsigned y;
        int unsigned n;
        r = '0;
        r.status = STATUS_OK;
        r.tstate = TSTATE_SUSPENDED;
        case (m)
            MODE_ACTIVATE:
            begin
                if (id < live_count())
                begin
                    ready_set(id);
                end
                else
                begin
                    r.status = STATUS_BAD_ID;
                end
            end
            MODE_DISPATCH:
            begin
                best = 0;
                if (grp_mask != EMPTY_ROW)
                begin
                    y = top_bit(grp_mask);
                    best = y * 8 + top_bit(row_mask[y]);
                end
                if (best > cur_task)
                begin
                    if (stk_depth < 64)
                    begin
                        preempt_stk[stk_depth] = cur_task;
                        stk_depth++;
                    end
                    ready_set(cur_task);
                    ready_clear(task_id_t'(best));
                    cur_task = task_id_t'(best);
                    r.switched = 1'b1;
                end
            end
            MODE_FINISH:
            begin
                if (stk_depth == 0)
                begin
                    r.status = STATUS_NO_RESUME;
                end
                else
                begin
                    stk_depth--;
                    cur_task = preempt_stk[stk_depth];
                    ready_clear(cur_task);
                    r.switched = 1'b1;
                end
            end
            MODE_QUERY:
            begin
                if (id == cur_task)
                begin
                    r.tstate = TSTATE_RUNNING;
                end
                else if (grp_mask[id[5:3]] && row_mask[id[5:3]][id[2:0]])
                begin
                    r.tstate = TSTATE_READY;
                end
            end
            MODE_START:
            begin
                grp_mask = EMPTY_ROW;
                foreach (row_mask[i])
                begin
                    row_mask[i] = EMPTY_ROW;
                end
                cur_task = IDLE_TASK;
                stk_depth = 0;
                n = live_count();
                for (int t = 0; t < n; t++)
                begin
                    if (autostart_reg[t])
                    begin
                        ready_set(task_id_t'(t));
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.running = cur_task;
    endtask

    task automatic note_fail(string what, int want, int got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        sched_result_t pred;
        sched_result_t got;
        sched_result_t want;
        bit moved;
        if (!rst_n)
        begin
            grp_mask = EMPTY_ROW;
            foreach (row_mask[i])
            begin
                row_mask[i] = EMPTY_ROW;
            end
            cur_task = IDLE_TASK;
            stk_depth = 0;
            count_reg = 7'd64;
            autostart_reg = 64'd1;
            quiet_cycles = 0;
        end
        else
        begin
            moved = 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == CFG_TASK_COUNT)
                begin
                    count_reg = cfg_data[6:0];
                end
                else
                begin
                    autostart_reg = cfg_data;
                end
            end
            if (in_valid && !in_stall)
            begin
                sched_apply(mode, task_id, pred);
                want_q.push_back(cmd_typed ? cmd_want : pred);
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                got = {status, switched, running_task, task_state};
                if (want_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("%0t: unexpected transaction, expected none actual %h",
                                 $time, got);
                    end
                end
                else
                begin
                    want = want_q.pop_front();
                    if (got.status !== want.status)
                    begin
                        note_fail("status", want.status, got.status);
                    end
                    if (got.switched !== want.switched)
                    begin
                        note_fail("switched", want.switched, got.switched);
                    end
                    if (got.running !== want.running)
                    begin
                        note_fail("running_task", want.running, got.running);
                    end
                    if (got.tstate !== want.tstate)
                    begin
                        note_fail("task_state", want.tstate, got.tstate);
                    end
                end
            end
            if (moved || (want_q.size() == 0 && !in_valid))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                    $display("tb_top: FAIL");
                    $finish;
                end
            end
        end
    end

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70)
        begin
            return 0;
        end
        if (r < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic plan_row_t cmd(mode_t m, task_id_t id);
        plan_row_t row;
        row.kind = ROW_CMD;
        row.mode = m;
        row.id = id;
        row.reg_idx = CFG_TASK_COUNT;
        row.reg_val = '0;
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic plan_row_t chk(mode_t m, task_id_t id, status_t st, logic sw,
                                      task_id_t run, tstate_t ts);
        plan_row_t row;
        row = cmd(m, id);
        row.typed = 1'b1;
        row.want = {st, sw, run, ts};
        return row;
    endfunction

    function automatic plan_row_t cfg(cfg_idx_t idx, logic [63:0] val);
        plan_row_t row;
        row = cmd(MODE_ACTIVATE, IDLE_TASK);
        row.kind = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    task automatic send_cmd(mode_t m, task_id_t id, bit typed, sched_result_t want, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode <= m;
        task_id <= id;
        cmd_typed = typed;
        cmd_want = want;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (want_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : result_sink
        int r;
        int quiet_left;
        int n;
        bit v;
        bit hold_done;
        out_stall = 1'b0;
        quiet_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            n = 1;
            v = 1'b0;
            if (hold_armed && !hold_done)
            begin
                hold_done = 1'b1;
                v = 1'b1;
                n = HOLD_CYCLES;
            end
            else if (quiet_left > 0)
            begin
                quiet_left--;
            end
            else if (r < 2)
            begin
                quiet_left = $urandom_range(40, 160);
            end
            else if (r >= 65 && r < 94)
            begin
                v = 1'b1;
                n = $urandom_range(1, 3);
            end
            else if (r >= 94)
            begin
                v = 1'b1;
                n = $urandom_range(10, 60);
            end
            out_stall <= v;
            repeat (n) @(negedge clk);
        end
    end

    initial
    begin : stimulus
        plan_row_t     plan [$];
        mode_t         m;
        task_id_t      id;
        int            r;
        int unsigned   live;
        bit            quiet;
        logic [6:0]    count_val;
        logic [63:0]   mask_val;

        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_ACTIVATE;
        task_id = IDLE_TASK;
        cfg_we = 1'b0;
        cfg_index = CFG_TASK_COUNT;
        cfg_data = '0;
        cmd_typed = 1'b0;
        cmd_want = '0;
        hold_armed = 1'b0;
        fail_count = 0;

        plan.push_back(chk(MODE_QUERY,    0,  STATUS_OK,        1'b0, 0,  TSTATE_RUNNING));
        plan.push_back(chk(MODE_FINISH,   0,  STATUS_NO_RESUME, 1'b0, 0,  TSTATE_SUSPENDED));
        plan.push_back(chk(MODE_DISPATCH, 0,  STATUS_OK,        1'b0, 0,  TSTATE_SUSPENDED));
        plan.push_back(chk(MODE_ACTIVATE, 63, STATUS_OK,        1'b0, 0,  TSTATE_SUSPENDED));
        plan.push_back(cmd(MODE_ACTIVATE, 0));
        plan.push_back(chk(MODE_DISPATCH, 0,  STATUS_OK,        1'b1, 63, TSTATE_SUSPENDED));
        plan.push_back(chk(MODE_QUERY,    0,  STATUS_OK,        1'b0, 63, TSTATE_READY));
        plan.push_back(chk(MODE_QUERY,    63, STATUS_OK,        1'b0, 63, TSTATE_RUNNING));
        plan.push_back(cmd(MODE_ACTIVATE, 62));
        plan.push_back(chk(MODE_DISPATCH, 0,  STATUS_OK,        1'b0, 63, TSTATE_SUSPENDED));
        plan.push_back(chk(MODE_FINISH,   0,  STATUS_OK,        1'b1, 0,  TSTATE_SUSPENDED));
        plan.push_back(chk(MODE_FINISH,   0,  STATUS_NO_RESUME, 1'b0, 0,  TSTATE_SUSPENDED));
        plan.push_back(cmd(MODE_DISPATCH, 0));
        plan.push_back(cmd(MODE_UNUSED_LO, 63));
        plan.push_back(cmd(MODE_UNUSED_HI, 0));
        plan.push_back(cmd(MODE_ACTIVATE, 8));
        plan.push_back(cmd(MODE_QUERY,    7));
        plan.push_back(chk(MODE_START,    0,  STATUS_OK,        1'b0, 0,  TSTATE_SUSPENDED));
        plan.push_back(chk(MODE_QUERY,    0,  STATUS_OK,        1'b0, 0,  TSTATE_RUNNING));
        plan.push_back(cfg(CFG_TASK_COUNT, 64'd0));
        plan.push_back(cfg(CFG_AUTOSTART, '1));
        plan.push_back(chk(MODE_START,    0,  STATUS_OK,        1'b0, 0,  TSTATE_SUSPENDED));
        plan.push_back(chk(MODE_ACTIVATE, 0,  STATUS_BAD_ID,    1'b0, 0,  TSTATE_SUSPENDED));
        plan.push_back(chk(MODE_DISPATCH, 0,  STATUS_OK,        1'b0, 0,  TSTATE_SUSPENDED));
        plan.push_back(cfg(CFG_TASK_COUNT, 64'd1));
        plan.push_back(chk(MODE_ACTIVATE, 1,  STATUS_BAD_ID,    1'b0, 0,  TSTATE_SUSPENDED));
        plan.push_back(chk(MODE_ACTIVATE, 0,  STATUS_OK,        1'b0, 0,  TSTATE_SUSPENDED));
        plan.push_back(cfg(CFG_TASK_COUNT, 64'd127));
        plan.push_back(chk(MODE_START,    0,  STATUS_OK,        1'b0, 0,  TSTATE_SUSPENDED));
        plan.push_back(chk(MODE_DISPATCH, 0,  STATUS_OK,        1'b1, 63, TSTATE_SUSPENDED));
        plan.push_back(cmd(MODE_QUERY,    62));
        plan.push_back(cmd(MODE_FINISH,   0));

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                in_valid <= 1'b0;
                wait_idle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                send_cmd(plan[i].mode, plan[i].id, plan[i].typed, plan[i].want,
                         pick_gap(1'b0));
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            in_valid <= 1'b0;
            wait_idle();
            case (p)
                0:       count_val = 7'd64;
                1:       count_val = 7'd1;
                2:       count_val = 7'd127;
                3:       count_val = 7'($urandom_range(2, 16));
                default: count_val = 7'($urandom_range(1, 64));
            endcase
            case (p % 4)
                0:       mask_val = {$urandom, $urandom};
                1:       mask_val = '1;
                2:       mask_val = '0;
                default: mask_val = 64'd1;
            endcase
            write_reg(CFG_TASK_COUNT, 64'(count_val));
            write_reg(CFG_AUTOSTART, mask_val);
            if (p == 2)
            begin
                hold_armed = 1'b1;
            end
            quiet = (p % 3 == 2);
            send_cmd(MODE_START, task_id_t'($urandom_range(0, 63)), 1'b0, '0, 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                live = live_count();
                r = $urandom_range(0, 99);
                if (live > 0 && $urandom_range(0, 99) < 85)
                begin
                    id = task_id_t'($urandom_range(0, live - 1));
                end
                else
                begin
                    id = task_id_t'($urandom_range(0, 63));
                end
                if (r < 36)
                begin
                    m = MODE_ACTIVATE;
                end
                else if (r < 58)
                begin
                    m = MODE_DISPATCH;
                end
                else if (r < 75)
                begin
                    m = MODE_FINISH;
                end
                else if (r < 92)
                begin
                    m = MODE_QUERY;
                end
                else if (r < 95)
                begin
                    m = MODE_START;
                end
                else
                begin
                    m = mode_t'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
                end
                send_cmd(m, id, 1'b0, '0, pick_gap(quiet));
            end
        end

        in_valid <= 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && want_q.size() == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/prms_pkg.sv
rtl/core/prms_ready_map.sv
rtl/core/priority_ready_map_scheduler.sv
rtl/core/prms_check.sv
tb/tb_top.sv
